### rtl/biq_pkg.sv
// Shared types, register codes and arithmetic helpers for the biquad section.
package biq_pkg;

  localparam int unsigned DataW  = 32;
  localparam int unsigned AccW   = 64;
  localparam int unsigned ShiftW = 5;
  localparam int unsigned AddrW  = 3;
  localparam int unsigned FracW  = 31;

  localparam logic [AccW-1:0]  Sat64Max = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [AccW-1:0]  Sat64Min = 64'h8000_0000_0000_0000;
  localparam logic [DataW-1:0] Sat32Max = 32'h7FFF_FFFF;
  localparam logic [DataW-1:0] Sat32Min = 32'h8000_0000;

  typedef enum logic [AddrW-1:0] {
    REG_B0    = 3'd0,
    REG_B1    = 3'd1,
    REG_B2    = 3'd2,
    REG_A1    = 3'd3,
    REG_A2    = 3'd4,
    REG_SHIFT = 3'd5
  } cfg_reg_e;

  typedef struct packed {
    logic signed [DataW-1:0] b0;
    logic signed [DataW-1:0] b1;
    logic signed [DataW-1:0] b2;
    logic signed [DataW-1:0] a1;
    logic signed [DataW-1:0] a2;
    logic [ShiftW-1:0]       ff_shift;
  } coef_t;

  // Pipeline control shared by the feedforward and feedback parts.
  typedef struct packed {
    logic en;      // the whole pipeline advances this cycle
    logic accept;  // an input beat is taken this cycle
  } pipe_ctl_t;

  // Exact signed 32 x 32 product.
  function automatic logic signed [AccW-1:0] mul32(input logic signed [DataW-1:0] a,
                                                   input logic signed [DataW-1:0] b);
    logic signed [AccW-1:0] ax;
    logic signed [AccW-1:0] bx;
    ax = AccW'(a);
    bx = AccW'(b);
    return ax * bx;
  endfunction

  // 64-bit add that clamps to the signed range on overflow.
  function automatic logic signed [AccW-1:0] sat_add64(input logic signed [AccW-1:0] a,
                                                       input logic signed [AccW-1:0] b);
    logic [AccW-1:0] sum;
    sum = a + b;
    if ((a[AccW-1] == b[AccW-1]) && (sum[AccW-1] != a[AccW-1])) begin
      return a[AccW-1] ? Sat64Min : Sat64Max;
    end
    return sum;
  endfunction

  // Drop the fraction bits and clamp the remaining 33-bit value to 32 bits.
  function automatic logic signed [DataW-1:0] round_sat32(input logic signed [AccW-1:0] acc);
    logic [DataW:0] hi;
    hi = acc[AccW-1:FracW];
    if (hi[DataW] != hi[DataW-1]) begin
      return hi[DataW] ? Sat32Min : Sat32Max;
    end
    return hi[DataW-1:0];
  endfunction

endpackage

### rtl/biq_ff.sv
// Feedforward part: input delay line, three products and their saturating sum.
module biq_ff import biq_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  pipe_ctl_t               ctl_i,
  input  logic signed [DataW-1:0] sample_i,
  input  coef_t                   coef_i,
  output logic                    valid_o,
  output logic signed [AccW-1:0]  acc_o
);

  logic signed [DataW-1:0] xd1_q, xd2_q;
  logic signed [DataW-1:0] xa_q, x1a_q, x2a_q;
  logic                    va_q, vb_q, vc_q;
  logic signed [AccW-1:0]  p0_q, p1_q, p2_q;
  logic signed [AccW-1:0]  acc_d, acc_q;

  // Sample history; it moves only when a beat is actually taken.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      xd1_q <= '0;
      xd2_q <= '0;
    end else if (ctl_i.accept) begin
      xd1_q <= sample_i;
      xd2_q <= xd1_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= 1'b0;
      vb_q <= 1'b0;
      vc_q <= 1'b0;
    end else if (ctl_i.en) begin
      va_q <= ctl_i.accept;
      vb_q <= va_q;
      vc_q <= vb_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.accept) begin
      xa_q  <= sample_i;
      x1a_q <= xd1_q;
      x2a_q <= xd2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.en) begin
      p0_q  <= mul32(coef_i.b0, xa_q);
      p1_q  <= mul32(coef_i.b1, x1a_q);
      p2_q  <= mul32(coef_i.b2, x2a_q);
      acc_q <= acc_d;
    end
  end

  always_comb begin
    acc_d = sat_add64(p0_q >>> coef_i.ff_shift, p1_q >>> coef_i.ff_shift);
    acc_d = sat_add64(acc_d, p2_q >>> coef_i.ff_shift);
  end

  assign valid_o = vc_q;
  assign acc_o   = acc_q;

endmodule

### rtl/biq_fb.sv
// Feedback part: output history, two feedback products and the output register.
module biq_fb import biq_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  pipe_ctl_t               ctl_i,
  input  logic                    valid_i,
  input  logic signed [AccW-1:0]  acc_i,
  input  coef_t                   coef_i,
  output logic                    valid_o,
  output logic signed [DataW-1:0] data_o
);

  logic                    ov_q;
  logic signed [DataW-1:0] y1_q, y2_q;
  logic signed [DataW-1:0] y_d;
  logic signed [AccW-1:0]  acc4;
  logic signed [AccW-1:0]  acc5;

  // The two feedback products run side by side; the adds keep their order.
  always_comb begin
    acc4 = sat_add64(acc_i, mul32(coef_i.a1, y1_q));
    acc5 = sat_add64(acc4, mul32(coef_i.a2, y2_q));
    y_d  = round_sat32(acc5);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ov_q <= 1'b0;
      y1_q <= '0;
      y2_q <= '0;
    end else if (ctl_i.en) begin
      ov_q <= valid_i;
      if (valid_i) begin
        y1_q <= y_d;
        y2_q <= y1_q;
      end
    end
  end

  // The newest output doubles as the one-sample output delay.
  assign valid_o = ov_q;
  assign data_o  = y1_q;

endmodule

### rtl/biquad_iir_section_fixed.sv
// Top level of the direct-form-1 biquad section: config registers and stream control.
// A sample passes the input, product, sum and output registers before the master side.
// Throughput: one sample per cycle unless stalled; feedback closes y1 through one register.
// The pipeline stalls as a whole only while a result waits and the master side is not ready.
// Reset (rst_ni low, asynchronous) clears coefficients, shift, sample and output history
// and all valid flags; the configuration port is always ready.
module biquad_iir_section_fixed import biq_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  // Input stream.
  input  logic             s_axis_tvalid,
  output logic             s_axis_tready,
  input  logic [DataW-1:0] s_axis_tdata,   // [31:0] sample_in
  // Output stream.
  output logic             m_axis_tvalid,
  input  logic             m_axis_tready,
  output logic [DataW-1:0] m_axis_tdata,   // [31:0] sample_out
  // Configuration write channel.
  input  logic             cfg_valid_i,
  output logic             cfg_ready_o,
  input  logic [AddrW-1:0] cfg_addr_i,
  input  logic [DataW-1:0] cfg_data_i
);

  coef_t     coef_q;
  pipe_ctl_t ctl;
  logic      ff_valid;
  logic signed [AccW-1:0] ff_acc;
  logic      out_valid;
  logic signed [DataW-1:0] out_data;

  // Registers are written by index; an index past the list is dropped.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      coef_q <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_addr_i)
        REG_B0:    coef_q.b0       <= cfg_data_i;
        REG_B1:    coef_q.b1       <= cfg_data_i;
        REG_B2:    coef_q.b2       <= cfg_data_i;
        REG_A1:    coef_q.a1       <= cfg_data_i;
        REG_A2:    coef_q.a2       <= cfg_data_i;
        REG_SHIFT: coef_q.ff_shift <= cfg_data_i[ShiftW-1:0];
        default:   ;
      endcase
    end
  end

  // Every stage moves together. The pipeline holds only while the output register
  // is full and not being drained, so a new beat is taken even while a result waits
  // as long as it is leaving in the same cycle.
  assign ctl.en         = !out_valid || m_axis_tready;
  assign ctl.accept     = s_axis_tvalid && ctl.en;
  assign s_axis_tready  = ctl.en;

  // Input register, three feedforward products and their shifted saturating sum.
  biq_ff u_ff (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ctl_i    (ctl),
    .sample_i (s_axis_tdata),
    .coef_i   (coef_q),
    .valid_o  (ff_valid),
    .acc_o    (ff_acc)
  );

  // Feedback terms, final scaling and the output register, which is also y1.
  biq_fb u_fb (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctl_i   (ctl),
    .valid_i (ff_valid),
    .acc_i   (ff_acc),
    .coef_i  (coef_q),
    .valid_o (out_valid),
    .data_o  (out_data)
  );

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = out_data;

endmodule

### rtl/biq_checker.sv
// Port-level checker for the biquad section and its bind to the top level.
module biq_checker import biq_pkg::*; (
  input logic             clk_i,
  input logic             rst_ni,
  input logic             s_axis_tready,
  input logic             m_axis_tvalid,
  input logic             m_axis_tready,
  input logic [DataW-1:0] m_axis_tdata
);

  // A stalled result keeps its valid.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("result beat dropped while stalled");

  // A stalled result keeps its data.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
    else $error("result data changed while stalled");

  // With nothing waiting at the output, the input side must be open.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_axis_tvalid |-> s_axis_tready)
    else $error("input stalled with an empty output register");

  // A full, stalled output register holds off the input side.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |-> !s_axis_tready)
    else $error("input taken while the pipeline is stalled");

  // Nothing is offered during reset.
  assert property (@(posedge clk_i) !rst_ni |-> !m_axis_tvalid)
    else $error("result valid during reset");

endmodule

bind biquad_iir_section_fixed biq_checker u_biq_checker (.*);

### tb/biquad_iir_section_fixed_tb.sv
// Self-checking testbench for the fixed-point direct-form-1 biquad section.
module biquad_iir_section_fixed_tb import biq_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  typedef logic signed [DataW-1:0] word_t;
  typedef logic signed [AccW-1:0]  acc_t;

  // Register indexes past the last coefficient; the block must ignore writes to them.
  localparam logic [AddrW-1:0] RegSpareLo = 3'd6;
  localparam logic [AddrW-1:0] RegSpareHi = 3'd7;

  localparam word_t WordMax = 32'sh7FFF_FFFF;
  localparam word_t WordMin = 32'sh8000_0000;

  // The slowest correct run is about 1650 beats, each paying the largest drawn gap and stall
  // plus the pipeline latency; the limit leaves a wide margin above that.
  localparam int unsigned CycleLimit = 400000;
  localparam int unsigned MaxReported = 10;
  localparam int unsigned RandomPhases = 16;
  localparam int unsigned BeatsPerPhase = 102;

  // Tracks coefficients and sample history and predicts each filtered output.
  class filter_tracker;
    word_t      b0, b1, b2, a1, a2;
    logic [4:0] shift;
    word_t      x1, x2, y1, y2;
    word_t      pending_outputs[$];
    int unsigned mismatches;

    function new();
      b0 = '0; b1 = '0; b2 = '0; a1 = '0; a2 = '0; shift = '0;
      x1 = '0; x2 = '0; y1 = '0; y2 = '0;
      mismatches = 0;
    endfunction

    function void write_reg(logic [AddrW-1:0] idx, logic [DataW-1:0] data);
      case (idx)
        REG_B0:    b0 = data;
        REG_B1:    b1 = data;
        REG_B2:    b2 = data;
        REG_A1:    a1 = data;
        REG_A2:    a2 = data;
        REG_SHIFT: shift = data[4:0];
        default: ;
      endcase
    endfunction

    // Signed add that clamps to the 64-bit range when the exact sum leaves it.
    function acc_t add_clamped(acc_t p, acc_t q);
      acc_t r;
      r = p + q;
      if (p[AccW-1] == q[AccW-1] && r[AccW-1] != p[AccW-1]) begin
        return p[AccW-1] ? acc_t'(Sat64Min) : acc_t'(Sat64Max);
      end
      return r;
    endfunction

    function acc_t product(word_t p, word_t q);
      acc_t pw, qw;
      pw = p;
      qw = q;
      return pw * qw;
    endfunction

    // Runs one sample through the filter and queues the output it must give.
    function void take_sample(word_t x);
      acc_t  acc, hi;
      word_t y;
      acc = product(b0, x) >>> shift;
      acc = add_clamped(acc, product(b1, x1) >>> shift);
      acc = add_clamped(acc, product(b2, x2) >>> shift);
      acc = add_clamped(acc, product(a1, y1));
      acc = add_clamped(acc, product(a2, y2));
      hi = acc >>> FracW;
      if (hi > acc_t'(WordMax)) begin
        y = WordMax;
      end else if (hi < acc_t'(WordMin)) begin
        y = WordMin;
      end else begin
        y = hi[DataW-1:0];
      end
      x2 = x1;
      x1 = x;
      y2 = y1;
      y1 = y;
      pending_outputs.push_back(y);
    endfunction

    function void match_output(word_t got);
      word_t want;
      if (pending_outputs.size() == 0) begin
        mismatches++;
        if (mismatches <= MaxReported) begin
          $display("unexpected output beat: sample_out %h", got);
        end
        return;
      end
      want = pending_outputs.pop_front();
      if (got !== want) begin
        mismatches++;
        if (mismatches <= MaxReported) begin
          $display("sample_out mismatch: expected %h, actual %h", want, got);
        end
      end
    endfunction

    function int unsigned outstanding();
      return pending_outputs.size();
    endfunction
  endclass

  // Every input starts at a known value from time zero; reset falls at time zero
  // through a scheduled update so that the block sees the falling edge.
  logic             clk_i = 1'b0;
  logic             rst_ni = 1'b1;
  logic             s_axis_tvalid = 1'b0;
  logic             s_axis_tready;
  logic [DataW-1:0] s_axis_tdata = '0;
  logic             m_axis_tvalid;
  logic             m_axis_tready = 1'b0;
  logic [DataW-1:0] m_axis_tdata;
  logic             cfg_valid_i = 1'b0;
  logic             cfg_ready_o;
  logic [AddrW-1:0] cfg_addr_i = '0;
  logic [DataW-1:0] cfg_data_i = '0;

  filter_tracker tracker = new();
  int unsigned   cycle_count = 0;
  int unsigned   stall_left = 0;
  // While set, neither the sender nor the receiver inserts idle cycles.
  bit            no_idle = 1'b0;

  biquad_iir_section_fixed dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_addr_i    (cfg_addr_i),
    .cfg_data_i    (cfg_data_i)
  );

  initial begin
    forever #10 clk_i = ~clk_i;
  end

  // The watchdog ends a hung run with the failure message.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("biquad_iir_section_fixed regression: fail");
      $finish;
    end
  end

  function automatic int unsigned idle_cycles();
    return no_idle ? 0 : $urandom_range(0, 16);
  endfunction

  // Output side. Every beat taken is checked against the oldest prediction,
  // and after each beat the receiver draws how long it holds tready low.
  // Values are sampled at the edge before any of this edge's updates land.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else if (m_axis_tvalid && m_axis_tready) begin
      tracker.match_output(m_axis_tdata);
      stall_left = idle_cycles();
      m_axis_tready <= (stall_left == 0);
    end else begin
      if (stall_left > 0) begin
        stall_left = stall_left - 1;
      end
      m_axis_tready <= (stall_left == 0);
    end
  end

  // Mixes the extremes, small magnitudes and full-range words so that the
  // saturation paths and the ordinary arithmetic both get exercised.
  function automatic word_t pick_word();
    case ($urandom_range(0, 9))
      0: return WordMax;
      1: return WordMin;
      2: return '0;
      3: return -word_t'($urandom_range(1, 255));
      4: return word_t'($urandom_range(0, 255));
      default: return word_t'($urandom);
    endcase
  endfunction

  // Coefficients below an eighth of full scale keep the feedback loop from
  // pinning the output at a rail, so the history actually matters.
  function automatic word_t gentle_coef();
    word_t raw;
    raw = $urandom;
    return raw >>> 3;
  endfunction

  // Leaves cfg_valid_i high so that back-to-back writes do not toggle it within one step.
  task automatic write_reg(logic [AddrW-1:0] idx, logic [DataW-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_addr_i  <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    tracker.write_reg(idx, data);
  endtask

  // Writes all six registers, optionally pokes the two spare indexes, then idles the port.
  task automatic program_filter(word_t b0, word_t b1, word_t b2, word_t a1, word_t a2,
                                logic [DataW-1:0] shift_word, bit poke_spares);
    write_reg(REG_B0, b0);
    write_reg(REG_B1, b1);
    write_reg(REG_B2, b2);
    write_reg(REG_A1, a1);
    write_reg(REG_A2, a2);
    write_reg(REG_SHIFT, shift_word);
    if (poke_spares) begin
      write_reg(RegSpareLo, $urandom);
      write_reg(RegSpareHi, $urandom);
    end
    cfg_valid_i <= 1'b0;
  endtask

  // Sends one sample; tvalid stays high into the next beat when no gap is drawn.
  task automatic send_sample(word_t x);
    int unsigned gap;
    gap = idle_cycles();
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata  <= $urandom;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= x;
    do @(posedge clk_i); while (!s_axis_tready);
    tracker.take_sample(x);
  endtask

  task automatic end_burst();
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= $urandom;
  endtask

  // Configuration only changes once every predicted output has come back.
  task automatic wait_drained();
    while (tracker.outstanding() != 0) @(posedge clk_i);
  endtask

  initial begin
    int unsigned leftover;
    bit          gentle;

    rst_ni <= 1'b0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Coefficients straight out of reset are all zero, so the output must be too.
    send_sample(WordMax);
    send_sample(WordMin);
    end_burst();
    wait_drained();

    // Most negative coefficients and samples: each product of two of them is +2^62, so the
    // first add already overflows the accumulator and the output clamps high.
    program_filter(WordMin, WordMin, WordMin, WordMin, WordMin, '0, 1'b0);
    send_sample(WordMin);
    send_sample(WordMin);
    send_sample(WordMin);
    send_sample(WordMax);
    send_sample(WordMax);
    end_burst();
    wait_drained();

    // Largest positive coefficients with the widest shift; the shift word
    // carries ones above bit 4 that the block must drop.
    program_filter(WordMax, WordMax, WordMax, WordMax, WordMax, 32'hFFFF_FFFF, 1'b0);
    send_sample(WordMin);
    send_sample(WordMax);
    send_sample(-word_t'(1));
    send_sample(word_t'(1));
    send_sample('0);
    end_burst();
    wait_drained();

    // Alternating signs drive the accumulator to the negative rail; writes to
    // the spare indexes must leave the filter as it is.
    program_filter(WordMax, WordMin, WordMax, WordMin, WordMax, 32'd1, 1'b1);
    send_sample(WordMax);
    send_sample(WordMin);
    send_sample(WordMax);
    send_sample(WordMin);
    end_burst();
    wait_drained();

    // Random phases: each one reprograms the filter and streams a run of samples.
    // Every fourth phase runs with no idle cycles on either side.
    for (int unsigned ph = 0; ph < RandomPhases; ph++) begin
      no_idle = (ph % 4 == 3);
      gentle  = $urandom_range(0, 2) != 0;
      if (gentle) begin
        program_filter(gentle_coef(), gentle_coef(), gentle_coef(), gentle_coef(),
                       gentle_coef(), $urandom, $urandom_range(0, 3) == 0);
      end else begin
        program_filter(pick_word(), pick_word(), pick_word(), pick_word(), pick_word(),
                       (ph == 5) ? 32'hFFFF_FFE0 : $urandom, $urandom_range(0, 3) == 0);
      end
      for (int unsigned n = 0; n < BeatsPerPhase; n++) begin
        send_sample(pick_word());
      end
      end_burst();
      wait_drained();
    end

    // Let the pipeline run on idle so that any stray output beat shows up.
    no_idle = 1'b0;
    repeat (10) @(posedge clk_i);
    leftover = tracker.outstanding();
    if (tracker.mismatches == 0 && leftover == 0) begin
      $display("biquad_iir_section_fixed regression: pass");
    end else begin
      $display("biquad_iir_section_fixed regression: fail");
    end
    $finish;
  end

endmodule
